@@ sv/bchr_pkg.sv @@
// Shared constants for the button click / hold / repeat state machine.
// No dependencies.
package bchr_pkg;

  localparam int BCHR_LEVEL_BITS = 8;
  localparam int BCHR_STEP_BITS  = 16;
  localparam int BCHR_TICK_BITS  = 32;
  localparam int BCHR_CNT_BITS   = 8;
  localparam int BCHR_DEB_BITS   = 17;
  localparam int BCHR_EV_BITS    = 3;
  localparam int BCHR_IDX_BITS   = 3;

  localparam logic [BCHR_STEP_BITS-1:0] BCHR_DEFAULT_CLICK = 16'd150;
  localparam logic [BCHR_STEP_BITS-1:0] BCHR_DEFAULT_HOLD  = 16'd300;

  typedef logic [BCHR_EV_BITS-1:0] bchr_event_t;

  localparam bchr_event_t EV_SILENT  = 3'd0;
  localparam bchr_event_t EV_NONE    = 3'd1;
  localparam bchr_event_t EV_PRESS   = 3'd2;
  localparam bchr_event_t EV_RELEASE = 3'd3;
  localparam bchr_event_t EV_CLICK   = 3'd4;
  localparam bchr_event_t EV_MULTI   = 3'd5;
  localparam bchr_event_t EV_HOLD    = 3'd6;

  typedef logic [BCHR_IDX_BITS-1:0] bchr_reg_idx_t;

  localparam bchr_reg_idx_t REG_RELEASED_LEVEL = 3'd0;
  localparam bchr_reg_idx_t REG_DEBOUNCE_LIMIT = 3'd1;
  localparam bchr_reg_idx_t REG_CLICK_TICKS    = 3'd2;
  localparam bchr_reg_idx_t REG_HOLD_TICKS     = 3'd3;
  localparam bchr_reg_idx_t REG_FAKE_ENABLE    = 3'd4;
  localparam bchr_reg_idx_t REG_FAKE_LEVEL     = 3'd5;

endpackage

@@ sv/button_click_hold_repeat_fsm.sv @@
// Debounced button state machine reporting press, release, click,
// multi-click and hold events, one result per poll. Uses bchr_pkg.
//
//   channel  signals                                             direction
//   in       in_valid, in_stall, in_sampled_level, in_tick_step  poll request in
//   out      out_valid, out_stall, out_event_code, out_is_pressed,
//            out_elapsed_ticks, out_click_count                  result out
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data           register write in
//
// A request is registered at acceptance and evaluated once the result
// register can take it; there debounce, tick count and mode update together
// and the result is registered. One request per cycle is sustained while
// out_stall is low. out_stall holds the result register, and the input
// register drains into it only when it is free. Synchronous active-low reset
// loads register defaults, clears machine state, leaves both channels empty.
module button_click_hold_repeat_fsm #(
  parameter int LEVEL_BITS = bchr_pkg::BCHR_LEVEL_BITS
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic [LEVEL_BITS-1:0]                     in_sampled_level,
  input  logic [bchr_pkg::BCHR_STEP_BITS-1:0]       in_tick_step,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic [bchr_pkg::BCHR_EV_BITS-1:0]         out_event_code,
  output logic                                      out_is_pressed,
  output logic [bchr_pkg::BCHR_TICK_BITS-1:0]       out_elapsed_ticks,
  output logic [bchr_pkg::BCHR_CNT_BITS-1:0]        out_click_count,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [bchr_pkg::BCHR_IDX_BITS-1:0]        cfg_index,
  input  logic [((LEVEL_BITS > bchr_pkg::BCHR_STEP_BITS) ? LEVEL_BITS :
                 bchr_pkg::BCHR_STEP_BITS)-1:0]     cfg_data
);
  import bchr_pkg::*;

  localparam logic [2:0] M_IDLE     = 3'd0;
  localparam logic [2:0] M_RELEASED = 3'd1;
  localparam logic [2:0] M_PRESSED  = 3'd2;
  localparam logic [2:0] M_REPEAT   = 3'd3;
  localparam logic [2:0] M_HOLD     = 3'd4;

  // configuration
  logic [LEVEL_BITS-1:0]     released_level_r;
  logic [BCHR_STEP_BITS-1:0] debounce_limit_r;
  logic [BCHR_STEP_BITS-1:0] click_ticks_r;
  logic [BCHR_STEP_BITS-1:0] hold_ticks_r;
  logic                      fake_enable_r;
  logic [LEVEL_BITS-1:0]     fake_level_r;

  // machine state
  logic [LEVEL_BITS-1:0]     stable_level_r, stable_level_nxt;
  logic [BCHR_DEB_BITS-1:0]  debounce_count_r, debounce_count_nxt;
  logic [BCHR_TICK_BITS-1:0] tick_total_r, tick_total_nxt;
  logic [BCHR_CNT_BITS-1:0]  press_count_r, press_count_nxt;
  logic [2:0]                mode_r, mode_nxt;

  // input register
  logic                      s1_valid_r;
  logic [LEVEL_BITS-1:0]     s1_level_r;
  logic [BCHR_STEP_BITS-1:0] s1_step_r;

  // result register
  logic                      out_valid_r;
  bchr_event_t               out_event_r;
  logic                      out_pressed_r;
  logic [BCHR_TICK_BITS-1:0] out_ticks_r;
  logic [BCHR_CNT_BITS-1:0]  out_count_r;

  logic                      advance;
  logic                      in_take;
  logic                      cfg_write;
  logic [LEVEL_BITS-1:0]     level;
  logic [BCHR_DEB_BITS-1:0]  deb_inc;
  logic [BCHR_TICK_BITS-1:0] tick_adv;
  logic [BCHR_TICK_BITS-1:0] click_lim;
  logic [BCHR_TICK_BITS-1:0] hold_lim;
  logic                      pressed;
  bchr_event_t               ev_nxt;

  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  assign click_lim = {{(BCHR_TICK_BITS-BCHR_STEP_BITS){1'b0}},
                      (click_ticks_r == '0) ? BCHR_DEFAULT_CLICK : click_ticks_r};
  assign hold_lim  = {{(BCHR_TICK_BITS-BCHR_STEP_BITS){1'b0}},
                      (hold_ticks_r == '0) ? BCHR_DEFAULT_HOLD : hold_ticks_r};

  always_comb begin
    level   = fake_enable_r ? fake_level_r : s1_level_r;
    deb_inc = debounce_count_r + 1'b1;

    // adopt a new level only after more than debounce_limit differing polls
    stable_level_nxt   = stable_level_r;
    debounce_count_nxt = '0;
    if (level != stable_level_r) begin
      if (deb_inc > {1'b0, debounce_limit_r}) begin
        stable_level_nxt = level;
      end else begin
        debounce_count_nxt = deb_inc;
      end
    end

    tick_adv = (mode_r != M_IDLE) ?
               tick_total_r + {{(BCHR_TICK_BITS-BCHR_STEP_BITS){1'b0}}, s1_step_r} :
               tick_total_r;
    pressed  = stable_level_nxt != released_level_r;

    tick_total_nxt  = tick_adv;
    press_count_nxt = press_count_r;
    mode_nxt        = mode_r;
    ev_nxt          = EV_SILENT;

    case (mode_r)
      M_IDLE: begin
        if (pressed) begin
          ev_nxt          = EV_PRESS;
          tick_total_nxt  = '0;
          press_count_nxt = '0;
          mode_nxt        = M_PRESSED;
        end else begin
          ev_nxt = EV_NONE;
        end
      end
      M_RELEASED: begin
        if (pressed) begin
          ev_nxt          = EV_PRESS;
          tick_total_nxt  = '0;
          press_count_nxt = press_count_r + 1'b1;
          mode_nxt        = M_REPEAT;
        end else if (tick_adv > click_lim) begin
          if (press_count_r == BCHR_CNT_BITS'(1)) begin
            ev_nxt = EV_CLICK;
          end else if (press_count_r > BCHR_CNT_BITS'(1)) begin
            ev_nxt = EV_MULTI;
          end
          mode_nxt = M_IDLE;
        end
      end
      M_PRESSED: begin
        if (!pressed) begin
          ev_nxt          = EV_RELEASE;
          tick_total_nxt  = '0;
          press_count_nxt = BCHR_CNT_BITS'(1);
          mode_nxt        = M_RELEASED;
        end else if (tick_adv > hold_lim) begin
          ev_nxt   = EV_HOLD;
          mode_nxt = M_HOLD;
        end
      end
      M_REPEAT: begin
        if (!pressed) begin
          ev_nxt = EV_RELEASE;
          if (tick_adv <= click_lim) begin
            tick_total_nxt = '0;
            mode_nxt       = M_RELEASED;
          end else begin
            mode_nxt = M_IDLE;
          end
        end else if (press_count_r == '0) begin
          // count wrapped: restart as a fresh press
          ev_nxt          = EV_PRESS;
          tick_total_nxt  = '0;
          press_count_nxt = '0;
          mode_nxt        = M_PRESSED;
        end
      end
      M_HOLD: begin
        if (pressed) begin
          ev_nxt = EV_HOLD;
        end else begin
          ev_nxt         = EV_RELEASE;
          tick_total_nxt = '0;
          mode_nxt       = M_IDLE;
        end
      end
      default: begin
        ev_nxt = EV_SILENT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      released_level_r <= '0;
      debounce_limit_r <= '0;
      click_ticks_r    <= BCHR_DEFAULT_CLICK;
      hold_ticks_r     <= BCHR_DEFAULT_HOLD;
      fake_enable_r    <= 1'b0;
      fake_level_r     <= '0;
      stable_level_r   <= '0;
      debounce_count_r <= '0;
      tick_total_r     <= '0;
      press_count_r    <= '0;
      mode_r           <= M_IDLE;
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (advance) begin
        stable_level_r   <= stable_level_nxt;
        debounce_count_r <= debounce_count_nxt;
        tick_total_r     <= tick_total_nxt;
        press_count_r    <= press_count_nxt;
        mode_r           <= mode_nxt;
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_RELEASED_LEVEL: begin
            released_level_r <= cfg_data[LEVEL_BITS-1:0];
            stable_level_r   <= cfg_data[LEVEL_BITS-1:0];
          end
          REG_DEBOUNCE_LIMIT: debounce_limit_r <= cfg_data[BCHR_STEP_BITS-1:0];
          REG_CLICK_TICKS:    click_ticks_r    <= cfg_data[BCHR_STEP_BITS-1:0];
          REG_HOLD_TICKS:     hold_ticks_r     <= cfg_data[BCHR_STEP_BITS-1:0];
          REG_FAKE_ENABLE:    fake_enable_r    <= cfg_data[0];
          REG_FAKE_LEVEL:     fake_level_r     <= cfg_data[LEVEL_BITS-1:0];
          default: begin
          end
        endcase
      end
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_level_r <= in_sampled_level;
      s1_step_r  <= in_tick_step;
    end
    if (advance) begin
      out_event_r   <= ev_nxt;
      out_pressed_r <= pressed;
      out_ticks_r   <= tick_total_nxt;
      out_count_r   <= press_count_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_code    = out_event_r;
  assign out_is_pressed    = out_pressed_r;
  assign out_elapsed_ticks = out_ticks_r;
  assign out_click_count   = out_count_r;

endmodule
